FILE: sv/udpc_pkg.sv
package udpc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_UDP_MODE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ADDRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_ADDRESS   = 2'd2;

    localparam logic [15:0] UDP_PROTOCOL = 16'd17;

    // Four address halves plus the protocol number fit in 19 bits.
    localparam int PSEUDO_W = 19;

    // The sum that closes one packet, and that sum plus the pseudo-header.
    localparam int FIN_W   = 18;
    localparam int TOTAL_W = 20;

    typedef struct packed {
        logic [15:0] word;
        logic [15:0] count;
        logic        last;
    } entry_t;

endpackage

FILE: sv/udp_ones_complement_checksum.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  data_byte[7:0], last_byte
// out       output     out_valid/out_stall  checksum[15:0], byte_total[15:0]
// cfg       input      cfg_write            cfg_index[1:0], cfg_data[31:0]
//
// One byte is taken every cycle while the queue is not full.
// A result passes the queue, the finish register and the output register.
// Reset clears the packet state, selects UDP mode and zeroes both addresses.
// A stalled result holds, bytes keep flowing into the queue until it fills,
// and in_stall rises only while the queue is full.
module udp_ones_complement_checksum #(
    parameter int QUEUE_DEPTH = udpc_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [15:0]                      checksum,
    output logic [15:0]                      byte_total,
    input  logic                             cfg_write,
    input  logic [udpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [udpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PSEUDO_W = udpc_pkg::PSEUDO_W;

    logic                 udp_mode_reg;
    logic [31:0]          source_address_reg;
    logic [31:0]          dest_address_reg;
    logic [PSEUDO_W-1:0]  pseudo_sum_reg;
    logic [PSEUDO_W-1:0]  pseudo_sum_next;

    logic                 q_full;
    logic                 q_empty;
    logic                 push;
    logic                 pop;
    udpc_pkg::entry_t     push_entry;
    udpc_pkg::entry_t     head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            udp_mode_reg       <= 1'b1;
            source_address_reg <= 32'd0;
            dest_address_reg   <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                udpc_pkg::CFG_UDP_MODE:       udp_mode_reg       <= cfg_data[0];
                udpc_pkg::CFG_SOURCE_ADDRESS: source_address_reg <= cfg_data;
                udpc_pkg::CFG_DEST_ADDRESS:   dest_address_reg   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    assign pseudo_sum_next = PSEUDO_W'(source_address_reg[31:16])
                           + PSEUDO_W'(source_address_reg[15:0])
                           + PSEUDO_W'(dest_address_reg[31:16])
                           + PSEUDO_W'(dest_address_reg[15:0])
                           + PSEUDO_W'(udpc_pkg::UDP_PROTOCOL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pseudo_sum_reg <= PSEUDO_W'(udpc_pkg::UDP_PROTOCOL);
        end
        else
        begin
            pseudo_sum_reg <= pseudo_sum_next;
        end
    end

    udpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    udpc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    udpc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .udp_mode   (udp_mode_reg),
        .pseudo_sum (pseudo_sum_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .checksum   (checksum),
        .byte_total (byte_total)
    );

endmodule

FILE: sv/udpc_front.sv
module udpc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             q_full,
    output logic             push,
    output udpc_pkg::entry_t push_entry
);

    logic [7:0]  hold_reg;
    logic [7:0]  hold_next;
    logic        odd_reg;
    logic        odd_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] count_inc;
    logic        accept;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign count_inc = count_reg + 16'd1;
    assign push      = accept && (last_byte || odd_reg);

    always_comb
    begin
        push_entry.word  = odd_reg ? {hold_reg, data_byte} : {data_byte, 8'h00};
        push_entry.count = count_inc;
        push_entry.last  = last_byte;
    end

    always_comb
    begin
        hold_next  = hold_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                odd_next   = 1'b0;
                count_next = 16'd0;
            end
            else
            begin
                count_next = count_inc;
                if (odd_reg)
                begin
                    odd_next = 1'b0;
                end
                else
                begin
                    hold_next = data_byte;
                    odd_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg   <= 1'b0;
            count_reg <= 16'd0;
        end
        else
        begin
            odd_reg   <= odd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

FILE: sv/udpc_fifo.sv
module udpc_fifo #(
    parameter int DEPTH = udpc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  udpc_pkg::entry_t push_entry,
    input  logic             pop,
    output udpc_pkg::entry_t head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    udpc_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == FULL_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/udpc_back.sv
module udpc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  udpc_pkg::entry_t               head,
    input  logic                           q_empty,
    output logic                           pop,
    input  logic                           udp_mode,
    input  logic [udpc_pkg::PSEUDO_W-1:0]  pseudo_sum,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [15:0]                    checksum,
    output logic [15:0]                    byte_total
);

    localparam int FIN_W   = udpc_pkg::FIN_W;
    localparam int TOTAL_W = udpc_pkg::TOTAL_W;

    logic [15:0]        acc_reg;
    logic [15:0]        acc_next;
    logic               fin_valid_reg;
    logic               fin_valid_next;
    logic [FIN_W-1:0]   fin_sum_reg;
    logic [FIN_W-1:0]   fin_sum_next;
    logic [15:0]        fin_count_reg;
    logic [15:0]        fin_count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        checksum_reg;
    logic [15:0]        checksum_next;
    logic [15:0]        byte_total_reg;
    logic [15:0]        byte_total_next;

    logic               fin_move;
    logic               fin_free;
    logic [16:0]        word_sum;
    logic [15:0]        acc_fold;
    logic [FIN_W-1:0]   fin_raw;
    logic [TOTAL_W-1:0] total;
    logic [16:0]        fold1;
    logic [15:0]        fold2;
    logic [15:0]        result;

    assign fin_move = fin_valid_reg && (!out_valid_reg || !out_stall);
    assign fin_free = !fin_valid_reg || fin_move;
    assign pop      = !q_empty && (!head.last || fin_free);

    // End-around carry keeps the 16-bit sum congruent to the full sum.
    assign word_sum = {1'b0, acc_reg} + {1'b0, head.word};
    assign acc_fold = word_sum[15:0] + {15'd0, word_sum[16]};

    assign fin_raw = FIN_W'(acc_reg) + FIN_W'(head.word)
                   + (udp_mode ? FIN_W'(head.count) : FIN_W'(0));

    assign total  = TOTAL_W'(fin_sum_reg) + (udp_mode ? TOTAL_W'(pseudo_sum) : TOTAL_W'(0));
    assign fold1  = {1'b0, total[15:0]} + 17'(total[TOTAL_W-1:16]);
    assign fold2  = fold1[15:0] + {15'd0, fold1[16]};
    assign result = ~fold2;

    always_comb
    begin
        acc_next        = acc_reg;
        fin_valid_next  = fin_valid_reg && !fin_move;
        fin_sum_next    = fin_sum_reg;
        fin_count_next  = fin_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        checksum_next   = checksum_reg;
        byte_total_next = byte_total_reg;

        if (pop)
        begin
            if (head.last)
            begin
                acc_next       = 16'd0;
                fin_valid_next = 1'b1;
                fin_sum_next   = fin_raw;
                fin_count_next = head.count;
            end
            else
            begin
                acc_next = acc_fold;
            end
        end

        if (fin_move)
        begin
            out_valid_next  = 1'b1;
            checksum_next   = (udp_mode && result == 16'd0) ? 16'hffff : result;
            byte_total_next = fin_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 16'd0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_sum_reg    <= fin_sum_next;
        fin_count_reg  <= fin_count_next;
        checksum_reg   <= checksum_next;
        byte_total_reg <= byte_total_next;
    end

    assign out_valid  = out_valid_reg;
    assign checksum   = checksum_reg;
    assign byte_total = byte_total_reg;

endmodule

FILE: sv/udpc_checker.sv
module udpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] checksum,
    input logic [15:0] byte_total
);

    // The pipeline comes out of reset empty and ready for bytes.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
        else $error("result or stall present during reset");

    // The queue can only fill while a finished result is waiting.
    a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(checksum) && $stable(byte_total))
        else $error("stalled result changed");

endmodule

bind udp_ones_complement_checksum udpc_checker u_checker (.*);
